// ===== src/chroma_histogram_skin_classifier_top_defines.svh =====
// assertion macros for the skin classifier checker
`ifndef CHROMA_HISTOGRAM_SKIN_CLASSIFIER_TOP_DEFINES_SVH
`define CHROMA_HISTOGRAM_SKIN_CLASSIFIER_TOP_DEFINES_SVH

// assert an implication that holds outside reset
`define CHSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// assert a condition in the cycle after an antecedent
`define CHSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/chsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsc_pkg
// shared types and constants of the chroma histogram skin classifier
// ----------------------------------------------------------------------------
package chsc_pkg;
	localparam int CHROMA_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF = 32;
	localparam int OUT_BITS = 32;
	localparam int PROB_BITS = 17;
	localparam int FRAC_BITS = 16;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_TRAIN = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_DIV,
		BK_OUT,
		BK_SWEEP
	} bk_state_t;
endpackage

// ===== src/chsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsc_front
// accepts items and holds them in a short queue for the back part
// ----------------------------------------------------------------------------
module chsc_front import chsc_pkg::*; #(
	parameter int CHROMA_BITS = CHROMA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               opcode,
	input  logic [7:0]               chroma_u,
	input  logic [7:0]               chroma_v,
	input  logic                     skin_flag,
	output logic                     cmd_valid,
	input  logic                     cmd_take,
	output op_t                      cmd_op,
	output logic [CHROMA_BITS-1:0]   cmd_u,
	output logic [CHROMA_BITS-1:0]   cmd_v,
	output logic                     cmd_skin
);
	localparam int ENT_BITS = 2 + 2 * CHROMA_BITS + 1;

	logic [ENT_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;
	logic                do_push, do_pop;
	logic [ENT_BITS-1:0] head;

	assign full = (cnt_q == 2'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;
	assign head = mem_q[rd_q];
	assign cmd_op = op_t'(head[ENT_BITS-1 -: 2]);
	assign cmd_u = head[2*CHROMA_BITS -: CHROMA_BITS];
	assign cmd_v = head[CHROMA_BITS -: CHROMA_BITS];
	assign cmd_skin = head[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= {opcode, chroma_u[CHROMA_BITS-1:0],
				chroma_v[CHROMA_BITS-1:0], skin_flag};
	end
endmodule

// ===== src/chsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsc_div
// restoring divider: floor(num / den), one quotient bit per cycle
// ----------------------------------------------------------------------------
module chsc_div #(
	parameter int NUM_BITS = 112,
	parameter int DEN_BITS = 96,
	parameter int Q_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [Q_BITS-1:0]   quo
);
	localparam int CNT_BITS = $clog2(Q_BITS + 1);

	logic [NUM_BITS-1:0]  rem_q;
	logic [DEN_BITS-1:0]  den_q;
	logic [Q_BITS-1:0]    quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic [NUM_BITS+Q_BITS-1:0] trial;
	logic                 fits;
	logic [NUM_BITS-1:0]  shifted_den;

	// compare against den shifted to the current quotient bit
	assign trial = {{Q_BITS{1'b0}}, den_q} << (cnt_q - CNT_BITS'(1));
	assign fits = (trial <= {{Q_BITS{1'b0}}, rem_q});
	assign shifted_den = trial[NUM_BITS-1:0];
	assign done = busy_q && (cnt_q == '0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_BITS'(Q_BITS);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			quo_q <= {quo_q[Q_BITS-2:0], fits};
			if (fits) rem_q <= rem_q - shifted_den;
		end
	end
endmodule

// ===== src/chsc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsc_back
// executes items against the bin memories and totals, holds one result
// ----------------------------------------------------------------------------
module chsc_back import chsc_pkg::*; #(
	parameter int CHROMA_BITS = CHROMA_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_take,
	input  op_t                    cmd_op,
	input  logic [CHROMA_BITS-1:0] cmd_u,
	input  logic [CHROMA_BITS-1:0] cmd_v,
	input  logic                   cmd_skin,
	output logic                   empty,
	input  logic                   pop,
	output logic [PROB_BITS-1:0]   probability,
	output logic [OUT_BITS-1:0]    bin_skin_count,
	output logic [OUT_BITS-1:0]    bin_nonskin_count,
	output logic [OUT_BITS-1:0]    max_skin_bin,
	output logic [OUT_BITS-1:0]    max_nonskin_bin,
	output logic [OUT_BITS-1:0]    total_pixels,
	output logic [OUT_BITS-1:0]    total_skin
);
	localparam int ADDR_BITS = 2 * CHROMA_BITS;
	localparam int DEPTH = 1 << ADDR_BITS;
	localparam int SUM_BITS = COUNT_BITS + 1;
	localparam int DEN_BITS = 2 * SUM_BITS;
	localparam int NUM_BITS = DEN_BITS + FRAC_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [CHROMA_BITS-1:0] NEUTRAL = CHROMA_BITS'(1) << (CHROMA_BITS - 1);
	localparam logic [PROB_BITS-1:0] Q_HALF = PROB_BITS'(1) << (FRAC_BITS - 1);

	logic [COUNT_BITS-1:0] skin_mem [DEPTH];
	logic [COUNT_BITS-1:0] nonskin_mem [DEPTH];

	bk_state_t state_q, state_d;
	logic [ADDR_BITS-1:0]  addr_q, sweep_q;
	op_t                   op_q;
	logic                  skin_q, neutral_q;
	logic [COUNT_BITS-1:0] s_rd_q, n_rd_q;
	logic [COUNT_BITS-1:0] s_new, n_new;
	logic [COUNT_BITS-1:0] s_res_q, n_res_q;
	logic [COUNT_BITS-1:0] pix_q, skt_q, speak_q, npeak_q;
	logic [SUM_BITS-1:0]   sq_a_q, sq_b_q;
	logic [DEN_BITS-1:0]   sprod_q, tprod_q;
	logic [PROB_BITS-1:0]  prob_q;
	logic                  res_valid_q;
	logic                  mul_q, start_q, div_start;
	logic                  div_done;
	logic [PROB_BITS-1:0]  div_quo;
	logic                  wr_en;

	assign s_new = (skin_q && s_rd_q != CMAX) ? s_rd_q + 1'b1 : s_rd_q;
	assign n_new = (!skin_q && n_rd_q != CMAX) ? n_rd_q + 1'b1 : n_rd_q;

	chsc_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS), .Q_BITS(PROB_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({sprod_q, {FRAC_BITS{1'b0}}}), .den(tprod_q),
		.done(div_done), .quo(div_quo)
	);

	assign empty = !res_valid_q;
	assign probability = prob_q;
	assign bin_skin_count = OUT_BITS'(s_res_q);
	assign bin_nonskin_count = OUT_BITS'(n_res_q);
	assign max_skin_bin = OUT_BITS'(speak_q);
	assign max_nonskin_bin = OUT_BITS'(npeak_q);
	assign total_pixels = OUT_BITS'(pix_q);
	assign total_skin = OUT_BITS'(skt_q);

	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		div_start = 1'b0;
		wr_en = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				// one result in flight at a time
				if (cmd_valid && !res_valid_q) begin
					cmd_take = 1'b1;
					state_d = (cmd_op == OP_CLEAR) ? BK_SWEEP : BK_READ;
				end
			end
			BK_READ: state_d = BK_EXEC;
			BK_EXEC: begin
				if (op_q == OP_TRAIN) wr_en = 1'b1;
				if (op_q == OP_QUERY && pix_q != '0 && (s_rd_q != '0 || n_rd_q != '0))
					state_d = BK_DIV;
				else
					state_d = BK_IDLE;
			end
			BK_DIV: begin
				div_start = start_q;
				if (div_done) state_d = BK_IDLE;
			end
			BK_SWEEP: begin
				if (sweep_q == '1) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_SWEEP;
			sweep_q <= '0;
			res_valid_q <= 1'b0;
			pix_q <= '0;
			skt_q <= '0;
			speak_q <= '0;
			npeak_q <= '0;
			mul_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && res_valid_q) res_valid_q <= 1'b0;
			if (state_q == BK_SWEEP) sweep_q <= sweep_q + 1'b1;
			if (cmd_take && cmd_op == OP_CLEAR) begin
				pix_q <= '0;
				skt_q <= '0;
				speak_q <= '0;
				npeak_q <= '0;
				res_valid_q <= 1'b1;
			end
			if (state_q == BK_EXEC) begin
				if (op_q == OP_TRAIN) begin
					if (pix_q != CMAX) pix_q <= pix_q + 1'b1;
					if (skin_q && skt_q != CMAX) skt_q <= skt_q + 1'b1;
					if (!neutral_q) begin
						if (s_new > speak_q) speak_q <= s_new;
						if (n_new > npeak_q) npeak_q <= n_new;
					end
				end
				if (state_d == BK_IDLE) res_valid_q <= 1'b1;
				mul_q <= 1'b1;
				start_q <= 1'b0;
			end else if (state_q == BK_DIV) begin
				// divider starts the cycle after the squares are registered
				mul_q <= 1'b0;
				start_q <= mul_q;
				if (div_done) res_valid_q <= 1'b1;
			end
		end
	end

	// bin memories: sweep clears after reset and on clear
	always_ff @(posedge clk) begin
		if (state_q == BK_SWEEP) begin
			skin_mem[sweep_q] <= '0;
			nonskin_mem[sweep_q] <= '0;
		end else if (wr_en) begin
			skin_mem[addr_q] <= s_new;
			nonskin_mem[addr_q] <= n_new;
		end
		s_rd_q <= skin_mem[addr_q];
		n_rd_q <= nonskin_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			addr_q <= {cmd_u, cmd_v};
			op_q <= cmd_op;
			skin_q <= cmd_skin;
			neutral_q <= (cmd_u == NEUTRAL) && (cmd_v == NEUTRAL);
			if (cmd_op == OP_CLEAR) begin
				s_res_q <= '0;
				n_res_q <= '0;
				prob_q <= '0;
			end
		end
		if (state_q == BK_EXEC) begin
			s_res_q <= (op_q == OP_TRAIN) ? s_new : s_rd_q;
			n_res_q <= (op_q == OP_TRAIN) ? n_new : n_rd_q;
			sq_a_q <= {1'b0, s_rd_q};
			sq_b_q <= {1'b0, s_rd_q} + {1'b0, n_rd_q};
			if (op_q == OP_QUERY && pix_q != '0)
				prob_q <= Q_HALF;
			else
				prob_q <= '0;
		end
		// squares registered before the divider starts
		if (state_q == BK_DIV && mul_q) begin
			sprod_q <= sq_a_q * sq_a_q;
			tprod_q <= sq_b_q * sq_b_q;
		end
		if (state_q == BK_DIV && div_done) prob_q <= div_quo;
	end
endmodule

// ===== src/chroma_histogram_skin_classifier_top.sv =====
`timescale 1ns / 1ps
// a clear's result is ready in the cycle after it is accepted; train, opcode 3 and a
// query of an empty bin pass the read and execute states, a query of a filled bin
// also squares the counts and runs a 17-step divider; the back part holds one
// transaction until its result is popped, and a clear also sweeps both bin memories;
// after reset the back part sweeps both bin memories before it starts items; the
// input queue holds two transactions meanwhile
// ----------------------------------------------------------------------------
// chroma_histogram_skin_classifier_top
// histogram skin classifier: input queue in front, bin engine in back
// ----------------------------------------------------------------------------
module chroma_histogram_skin_classifier_top import chsc_pkg::*; #(
	parameter int CHROMA_BITS = CHROMA_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           opcode,
	input  logic [7:0]           chroma_u,
	input  logic [7:0]           chroma_v,
	input  logic                 skin_flag,
	output logic                 empty,
	input  logic                 pop,
	output logic [16:0]          probability,
	output logic [31:0]          bin_skin_count,
	output logic [31:0]          bin_nonskin_count,
	output logic [31:0]          max_skin_bin,
	output logic [31:0]          max_nonskin_bin,
	output logic [31:0]          total_pixels,
	output logic [31:0]          total_skin
);
	logic                   cmd_valid, cmd_take, cmd_skin;
	op_t                    cmd_op;
	logic [CHROMA_BITS-1:0] cmd_u, cmd_v;

	chsc_front #(.CHROMA_BITS(CHROMA_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .chroma_u(chroma_u), .chroma_v(chroma_v),
		.skin_flag(skin_flag), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd_op(cmd_op), .cmd_u(cmd_u), .cmd_v(cmd_v), .cmd_skin(cmd_skin)
	);

	chsc_back #(.CHROMA_BITS(CHROMA_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd_op(cmd_op), .cmd_u(cmd_u), .cmd_v(cmd_v), .cmd_skin(cmd_skin),
		.empty(empty), .pop(pop), .probability(probability),
		.bin_skin_count(bin_skin_count), .bin_nonskin_count(bin_nonskin_count),
		.max_skin_bin(max_skin_bin), .max_nonskin_bin(max_nonskin_bin),
		.total_pixels(total_pixels), .total_skin(total_skin)
	);
endmodule

// ===== src/chsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chsc_checker
// port-level checks of the skin classifier
// ----------------------------------------------------------------------------
`include "chroma_histogram_skin_classifier_top_defines.svh"
module chsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [16:0] probability,
	input logic [31:0] total_pixels,
	input logic [31:0] total_skin,
	input logic [31:0] max_skin_bin,
	input logic [31:0] bin_skin_count
);
	`CHSC_ASSERT_IMP(a_prob_range, clk, arst_n, !empty, probability <= 17'd65536, "probability above one")
	`CHSC_ASSERT_IMP(a_skin_le_total, clk, arst_n, !empty, total_skin <= total_pixels, "skin total above pixel total")
	`CHSC_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(probability), "waiting result changed")
	`CHSC_ASSERT_IMP(a_peak_le_total, clk, arst_n, !empty, max_skin_bin <= total_skin && bin_skin_count <= total_skin, "bin count above skin total")
endmodule

bind chroma_histogram_skin_classifier_top chsc_checker u_chsc_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.probability(probability), .total_pixels(total_pixels),
	.total_skin(total_skin), .max_skin_bin(max_skin_bin),
	.bin_skin_count(bin_skin_count)
);

// ===== dv/chroma_histogram_skin_classifier_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_histogram_skin_classifier_top_tb
// drives train, query, clear and unused-opcode transactions into the skin
// classifier, predicts every result from a behavioral histogram model and
// compares each popped transaction field by field, under random stalls
// ----------------------------------------------------------------------------
module chroma_histogram_skin_classifier_top_tb;
	import chsc_pkg::*;

	typedef struct packed {
		logic [16:0] prob;
		logic [31:0] skin_cnt;
		logic [31:0] nonskin_cnt;
		logic [31:0] skin_peak;
		logic [31:0] nonskin_peak;
		logic [31:0] pix_total;
		logic [31:0] skin_sum;
	} verdict_t;

	typedef struct {
		op_t        op;
		logic [7:0] u;
		logic [7:0] v;
		logic       flag;
		logic       typed;
		logic [16:0] prob;
	} row_t;

	localparam int RAND_ITEMS = 680;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  opcode;
	logic [7:0]  chroma_u;
	logic [7:0]  chroma_v;
	logic        skin_flag;
	logic        empty;
	logic        pop;
	logic [16:0] probability;
	logic [31:0] bin_skin_count;
	logic [31:0] bin_nonskin_count;
	logic [31:0] max_skin_bin;
	logic [31:0] max_nonskin_bin;
	logic [31:0] total_pixels;
	logic [31:0] total_skin;

	// histogram model state
	logic [31:0] skin_hist[int];
	logic [31:0] nonskin_hist[int];
	logic [31:0] pix_cnt, skin_cnt, skin_peak, nonskin_peak;

	verdict_t verdicts_pending[$];
	int       n_errors;
	int       n_checked;
	int       n_sent;
	int       n_queries;
	int       n_clears;
	int       idle_phase;
	bit       hold_req;
	int       hold_cnt;

	chroma_histogram_skin_classifier_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.chroma_u(chroma_u), .chroma_v(chroma_v), .skin_flag(skin_flag),
		.empty(empty), .pop(pop), .probability(probability),
		.bin_skin_count(bin_skin_count), .bin_nonskin_count(bin_nonskin_count),
		.max_skin_bin(max_skin_bin), .max_nonskin_bin(max_nonskin_bin),
		.total_pixels(total_pixels), .total_skin(total_skin)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("timeout with %0d transactions outstanding", verdicts_pending.size());
		$display("chroma_histogram_skin_classifier_top_tb failed");
		$finish;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] x);
		return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
	endfunction

	// advance the histogram model by one transaction and return its result
	function automatic verdict_t classify(op_t op, logic [7:0] u, logic [7:0] v, logic f);
		verdict_t r;
		int idx;
		logic [127:0] s, t;
		idx = {u, v};
		r.prob = '0;
		if (!skin_hist.exists(idx)) skin_hist[idx] = '0;
		if (!nonskin_hist.exists(idx)) nonskin_hist[idx] = '0;
		case (op)
			OP_TRAIN: begin
				if (f) begin
					skin_hist[idx] = sat_inc(skin_hist[idx]);
					skin_cnt = sat_inc(skin_cnt);
				end else begin
					nonskin_hist[idx] = sat_inc(nonskin_hist[idx]);
				end
				// neutral gray bin never moves the peaks
				if (!(u == 8'd128 && v == 8'd128)) begin
					if (skin_hist[idx] > skin_peak) skin_peak = skin_hist[idx];
					if (nonskin_hist[idx] > nonskin_peak) nonskin_peak = nonskin_hist[idx];
				end
				pix_cnt = sat_inc(pix_cnt);
			end
			OP_QUERY: begin
				s = skin_hist[idx];
				t = s + nonskin_hist[idx];
				if (pix_cnt == 0) r.prob = '0;
				else if (t == 0) r.prob = 17'd32768;
				else r.prob = 17'((s * s * 128'd65536) / (t * t));
			end
			OP_CLEAR: begin
				skin_hist.delete();
				nonskin_hist.delete();
				skin_hist[idx] = '0;
				nonskin_hist[idx] = '0;
				pix_cnt = '0;
				skin_cnt = '0;
				skin_peak = '0;
				nonskin_peak = '0;
			end
			default: ;
		endcase
		r.skin_cnt = skin_hist[idx];
		r.nonskin_cnt = nonskin_hist[idx];
		r.skin_peak = skin_peak;
		r.nonskin_peak = nonskin_peak;
		r.pix_total = pix_cnt;
		r.skin_sum = skin_cnt;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	task automatic send(op_t op, logic [7:0] u, logic [7:0] v, logic f,
			logic typed, logic [16:0] typed_prob);
		verdict_t r;
		push <= 1'b1;
		opcode <= op;
		chroma_u <= u;
		chroma_v <= v;
		skin_flag <= f;
		@(posedge clk);
		while (full) @(posedge clk);
		r = classify(op, u, v, f);
		if (typed) r.prob = typed_prob;
		verdicts_pending.insert(verdicts_pending.size(), r);
		n_sent++;
		if (op == OP_QUERY) n_queries++;
		if (op == OP_CLEAR) n_clears++;
		// idle cycles drawn one at a time
		while ((idle_phase == 0 && $urandom_range(99) < 31) ||
				(idle_phase == 1 && $urandom_range(99) < 66)) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	// result side: pop with phase-dependent stalls, plus one long hold-off
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && pop && !empty) begin
			if (verdicts_pending.size() == 0) begin
				$display("unexpected transaction at %0t", $realtime);
				n_errors++;
			end else begin
				w = verdicts_pending.pop_front();
				n_checked++;
				if (probability !== w.prob)
					report("probability", 32'(probability), 32'(w.prob));
				if (bin_skin_count !== w.skin_cnt)
					report("bin_skin_count", bin_skin_count, w.skin_cnt);
				if (bin_nonskin_count !== w.nonskin_cnt)
					report("bin_nonskin_count", bin_nonskin_count, w.nonskin_cnt);
				if (max_skin_bin !== w.skin_peak)
					report("max_skin_bin", max_skin_bin, w.skin_peak);
				if (max_nonskin_bin !== w.nonskin_peak)
					report("max_nonskin_bin", max_nonskin_bin, w.nonskin_peak);
				if (total_pixels !== w.pix_total)
					report("total_pixels", total_pixels, w.pix_total);
				if (total_skin !== w.skin_sum) report("total_skin", total_skin, w.skin_sum);
			end
		end
		if (hold_req && hold_cnt == 0) begin
			hold_cnt <= HOLD_CYCLES;
			hold_req <= 1'b0;
			pop <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			pop <= 1'b0;
		end else if (idle_phase == 0) begin
			pop <= ($urandom_range(99) >= 66);
		end else if (idle_phase == 1) begin
			pop <= ($urandom_range(99) >= 31);
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		row_t rows[] = '{
			'{OP_QUERY, 8'd0,   8'd0,   1'b0, 1'b1, 17'd0},
			'{OP_TRAIN, 8'd0,   8'd0,   1'b1, 1'b0, 17'd0},
			'{OP_QUERY, 8'd5,   8'd5,   1'b0, 1'b1, 17'd32768},
			'{OP_QUERY, 8'd0,   8'd0,   1'b1, 1'b1, 17'd65536},
			'{OP_TRAIN, 8'd255, 8'd255, 1'b0, 1'b0, 17'd0},
			'{OP_QUERY, 8'd255, 8'd255, 1'b0, 1'b1, 17'd0},
			'{OP_TRAIN, 8'd128, 8'd128, 1'b1, 1'b0, 17'd0},
			'{OP_TRAIN, 8'd128, 8'd128, 1'b1, 1'b0, 17'd0},
			'{OP_TRAIN, 8'd128, 8'd128, 1'b0, 1'b0, 17'd0},
			'{OP_QUERY, 8'd128, 8'd128, 1'b0, 1'b0, 17'd0},
			'{OP_TRAIN, 8'd255, 8'd0,   1'b1, 1'b0, 17'd0},
			'{OP_TRAIN, 8'd255, 8'd0,   1'b0, 1'b0, 17'd0},
			'{OP_QUERY, 8'd255, 8'd0,   1'b0, 1'b1, 17'd16384},
			'{OP_TRAIN, 8'd128, 8'd127, 1'b1, 1'b0, 17'd0},
			'{OP_NOP,   8'd170, 8'd85,  1'b1, 1'b0, 17'd0},
			'{OP_NOP,   8'd255, 8'd0,   1'b0, 1'b1, 17'd0},
			'{OP_CLEAR, 8'd255, 8'd0,   1'b1, 1'b1, 17'd0},
			'{OP_QUERY, 8'd255, 8'd0,   1'b0, 1'b1, 17'd0},
			'{OP_TRAIN, 8'd0,   8'd255, 1'b0, 1'b0, 17'd0},
			'{OP_QUERY, 8'd0,   8'd255, 1'b0, 1'b1, 17'd0},
			'{OP_QUERY, 8'd1,   8'd1,   1'b0, 1'b1, 17'd32768}
		};
		logic [7:0] hot_u[8], hot_v[8];
		int pick;
		op_t op;
		logic [7:0] u, v;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		opcode = OP_NOP;
		chroma_u = '0;
		chroma_v = '0;
		skin_flag = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		idle_phase = 0;
		pix_cnt = '0;
		skin_cnt = '0;
		skin_peak = '0;
		nonskin_peak = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].op, rows[i].u, rows[i].v, rows[i].flag, rows[i].typed, rows[i].prob);
		for (int k = 0; k < 8; k++) begin
			hot_u[k] = $urandom_range(255);
			hot_v[k] = $urandom_range(255);
		end
		hot_u[0] = 8'd128;
		hot_v[0] = 8'd128;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_phase = (n < RAND_ITEMS / 3) ? 0 : (n < 2 * RAND_ITEMS / 3) ? 1 : 2;
			if (n == 100) hold_req = 1'b1;
			// let the pipeline drain completely once
			if (n == 300) begin
				push <= 1'b0;
				wait (verdicts_pending.size() == 0);
			end
			pick = $urandom_range(999);
			// mostly hot bins so counts climb and the peaks move
			if ($urandom_range(9) < 8) begin
				u = hot_u[$urandom_range(7)];
				v = hot_v[$urandom_range(7)];
				if (u == 8'd128 && $urandom_range(1)) v = 8'd128;
			end else begin
				u = $urandom_range(255);
				v = $urandom_range(255);
			end
			if (pick < 3) op = OP_CLEAR;
			else if (pick < 40) op = OP_NOP;
			else if (pick < 400) op = OP_QUERY;
			else op = OP_TRAIN;
			send(op, u, v, $urandom_range(1), 1'b0, '0);
		end
		push <= 1'b0;
		wait (verdicts_pending.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d transactions sent, %0d queries, %0d clears, %0d results checked",
			n_sent, n_queries, n_clears, n_checked);
		$display("covered empty, neutral, mixed and unused-opcode bins under stalls");
		if (n_errors == 0 && verdicts_pending.size() == 0)
			$display("chroma_histogram_skin_classifier_top_tb passed");
		else
			$display("chroma_histogram_skin_classifier_top_tb failed");
		$finish;
	end
endmodule
